// ===== design/blf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blf_pkg
// Shared types, constants and the fold function of the binary lifting block.
// ----------------------------------------------------------------------------
package blf_pkg;

  localparam int NODES_DEF  = 256;
  localparam int LEVELS_DEF = 60;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         node_index;
    logic [7:0]         next_node;
    logic               has_next;
    logic signed [63:0] entry_value;
    logic [59:0]        step_count;
  } in_t;

  typedef struct packed {
    logic [7:0]         end_node;
    logic               end_valid;
    logic signed [63:0] folded_value;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_BRD, ST_BW1, ST_BW2, ST_QSCAN, ST_QWAIT, ST_DONE
  } state_t;

  function automatic logic [63:0] unity(input logic mode);
    unity = mode ? {64{1'b1}} : 64'd0;
  endfunction

  function automatic logic [63:0] combine(input logic mode, input logic [63:0] x,
                                          input logic [63:0] y);
    if (!mode) combine = x + y;
    else if (y == {64{1'b1}}) combine = x;
    else combine = y;
  endfunction

endpackage
`default_nettype wire

// ===== design/binary_lifting_fold.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_lifting_fold
// Doubling table over a functional graph with a fold of node values.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result appears
// on out_data for one cycle with out_valid high and must be taken then. A query
// walks the levels from the top down through ST_QSCAN, entering ST_QWAIT for each
// set step bit. A build goes through ST_BRD, ST_BW1 and, for a defined link,
// ST_BW2 for each of the (LEVELS-1)*NODES entries, as each table has a single
// read port. A clearing pass over all 2^(clog2(LEVELS)+clog2(NODES)) entries
// (16384 by default) runs after reset through both tables and after a write of
// fold_mode through the fold table only, during which busy is high.
// ----------------------------------------------------------------------------
module binary_lifting_fold #(
  parameter int NODES  = blf_pkg::NODES_DEF,
  parameter int LEVELS = blf_pkg::LEVELS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire blf_pkg::in_t  in_data,
  output logic               out_valid,
  output blf_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata
);

  localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW    = NW + LW;
  localparam int DEPTH = 1 << AW;

  blf_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]   d_r, d_nxt;
  logic [NW-1:0]   i_r, i_nxt;
  logic [NW-1:0]   cur_r, cur_nxt;
  logic [59:0]     steps_r, steps_nxt;
  logic [63:0]     acc_r, acc_nxt;
  logic            ok_r, ok_nxt;
  logic [63:0]     fi_r, fi_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            clrj_r, clrj_nxt;
  logic            mode_r, mode_nxt;

  logic          j_we, f_we;
  logic [AW-1:0] waddr, raddr;
  logic [8:0]    j_wdata, j_rdata;
  logic [63:0]   f_wdata, f_rdata;
  logic          link_ok;

  blf_ram #(.WIDTH(9), .DEPTH(DEPTH)) u_jump (
    .clk(clk), .we(j_we), .waddr(waddr), .wdata(j_wdata), .raddr(raddr), .rdata(j_rdata)
  );

  blf_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_fold (
    .clk(clk), .we(f_we), .waddr(waddr), .wdata(f_wdata), .raddr(raddr), .rdata(f_rdata)
  );

  assign link_ok = j_rdata[8] && (32'(j_rdata[7:0]) < NODES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blf_pkg::ST_CLEAR;
      clr_r   <= '0;
      clrj_r  <= 1'b1;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      clrj_r  <= clrj_nxt;
      mode_r  <= mode_nxt;
    end
    d_r     <= d_nxt;
    i_r     <= i_nxt;
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
    acc_r   <= acc_nxt;
    ok_r    <= ok_nxt;
    fi_r    <= fi_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    i_nxt     = i_r;
    cur_nxt   = cur_r;
    steps_nxt = steps_r;
    acc_nxt   = acc_r;
    ok_nxt    = ok_r;
    fi_nxt    = fi_r;
    clr_nxt   = clr_r;
    clrj_nxt  = clrj_r;
    mode_nxt  = mode_r;
    j_we      = 1'b0;
    f_we      = 1'b0;
    waddr     = {d_r, i_r};
    j_wdata   = 9'd0;
    f_wdata   = blf_pkg::unity(mode_r);
    raddr     = {d_r, i_r};
    out_valid = 1'b0;
    busy      = (state_r != blf_pkg::ST_IDLE);
    out_data  = '{end_node: cur_r[7:0], end_valid: ok_r, folded_value: acc_r};

    case (state_r)
      blf_pkg::ST_CLEAR: begin
        waddr = clr_r;
        j_we  = clrj_r;
        f_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) state_nxt = blf_pkg::ST_IDLE;
        if (cfg_we) begin
          mode_nxt  = cfg_wdata;
          clr_nxt   = '0;
          state_nxt = blf_pkg::ST_CLEAR;
        end
      end
      blf_pkg::ST_IDLE: begin
        cur_nxt = '0;
        ok_nxt  = 1'b0;
        acc_nxt = '0;
        d_nxt   = '0;
        i_nxt   = '0;
        if (start) begin
          state_nxt = blf_pkg::ST_DONE;
          case (in_data.command)
            blf_pkg::CMD_LOAD: begin
              waddr   = {LW'(0), NW'(in_data.node_index)};
              j_wdata = (in_data.has_next && 32'(in_data.next_node) < NODES)
                        ? {1'b1, in_data.next_node} : 9'd0;
              f_wdata = in_data.entry_value;
              j_we    = (32'(in_data.node_index) < NODES);
              f_we    = j_we;
            end
            blf_pkg::CMD_BUILD: begin
              if (LEVELS > 1) state_nxt = blf_pkg::ST_BRD;
            end
            blf_pkg::CMD_QUERY: begin
              cur_nxt   = NW'(in_data.node_index);
              acc_nxt   = blf_pkg::unity(mode_r);
              steps_nxt = in_data.step_count;
              d_nxt     = LW'(LEVELS - 1);
              if (32'(in_data.node_index) < NODES && (in_data.step_count >> LEVELS) == '0) begin
                ok_nxt    = 1'b1;
                state_nxt = blf_pkg::ST_QSCAN;
              end
            end
            default: ;
          endcase
        end
        if (cfg_we) begin
          mode_nxt  = cfg_wdata;
          clr_nxt   = '0;
          clrj_nxt  = 1'b0;
          state_nxt = blf_pkg::ST_CLEAR;
        end
      end
      blf_pkg::ST_BRD: begin
        state_nxt = blf_pkg::ST_BW1;
      end
      blf_pkg::ST_BW1: begin
        fi_nxt = f_rdata;
        raddr  = {d_r, NW'(j_rdata[7:0])};
        if (link_ok) begin
          state_nxt = blf_pkg::ST_BW2;
        end else begin
          waddr = {d_r + 1'b1, i_r};
          j_we  = 1'b1;
          f_we  = 1'b1;
          state_nxt = blf_pkg::ST_BRD;
          i_nxt = i_r + 1'b1;
          if (32'(i_r) == NODES - 1) begin
            i_nxt = '0;
            d_nxt = d_r + 1'b1;
            if (32'(d_r) == LEVELS - 2) state_nxt = blf_pkg::ST_DONE;
          end
        end
      end
      blf_pkg::ST_BW2: begin
        waddr   = {d_r + 1'b1, i_r};
        j_we    = 1'b1;
        f_we    = 1'b1;
        j_wdata = j_rdata;
        f_wdata = blf_pkg::combine(mode_r, fi_r, f_rdata);
        state_nxt = blf_pkg::ST_BRD;
        i_nxt = i_r + 1'b1;
        if (32'(i_r) == NODES - 1) begin
          i_nxt = '0;
          d_nxt = d_r + 1'b1;
          if (32'(d_r) == LEVELS - 2) state_nxt = blf_pkg::ST_DONE;
        end
      end
      blf_pkg::ST_QSCAN: begin
        raddr = {d_r, cur_r};
        if (steps_r[0 +: 1] == 1'b0 && ((steps_r >> d_r) & 60'd1) == 60'd0) begin
          if (d_r == '0) state_nxt = blf_pkg::ST_DONE;
          else d_nxt = d_r - 1'b1;
        end else if (((steps_r >> d_r) & 60'd1) == 60'd0) begin
          if (d_r == '0) state_nxt = blf_pkg::ST_DONE;
          else d_nxt = d_r - 1'b1;
        end else begin
          state_nxt = blf_pkg::ST_QWAIT;
        end
      end
      blf_pkg::ST_QWAIT: begin
        if (!link_ok) begin
          ok_nxt    = 1'b0;
          state_nxt = blf_pkg::ST_DONE;
        end else begin
          acc_nxt = blf_pkg::combine(mode_r, acc_r, f_rdata);
          cur_nxt = NW'(j_rdata[7:0]);
          if (d_r == '0) state_nxt = blf_pkg::ST_DONE;
          else begin
            d_nxt     = d_r - 1'b1;
            state_nxt = blf_pkg::ST_QSCAN;
          end
        end
      end
      blf_pkg::ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = blf_pkg::ST_IDLE;
      end
      default: state_nxt = blf_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/blf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module blf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== tb/sv/binary_lifting_fold_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_lifting_fold_tb
// Drives load, build, query and no-op transactions through the doubling-table block
// in both fold modes, predicts every result with its own copy of the jump and
// fold tables, and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module binary_lifting_fold_tb;

  localparam int          NODES    = blf_pkg::NODES_DEF;
  localparam int          LEVELS   = blf_pkg::LEVELS_DEF;
  localparam logic [1:0]  CMD_NOP  = 2'd3;
  localparam int          IDLE_MAX = 200000;

  class lift_scoreboard;
    bit [8:0]  hop [LEVELS][NODES];
    bit [63:0] acc [LEVELS][NODES];
    bit        mode;
    blf_pkg::out_t awaited[$];
    int        errors;
    int        loads, builds, queries, valid_walks;

    function new();
      mode = 0;
      errors = 0;
      for (int d = 0; d < LEVELS; d++)
        for (int i = 0; i < NODES; i++) begin
          hop[d][i] = '0;
          acc[d][i] = '0;
        end
    endfunction

    function bit [63:0] neutral();
      return mode ? {64{1'b1}} : 64'd0;
    endfunction

    function bit [63:0] fold_pair(bit [63:0] x, bit [63:0] y);
      if (!mode) return x + y;
      return (y == {64{1'b1}}) ? x : y;
    endfunction

    function void set_mode(bit m);
      mode = m;
      for (int d = 0; d < LEVELS; d++)
        for (int i = 0; i < NODES; i++) acc[d][i] = neutral();
    endfunction

    function void note_transaction(blf_pkg::in_t t);
      blf_pkg::out_t r;
      bit [7:0] cur;
      r = '0;
      case (t.command)
        blf_pkg::CMD_LOAD: begin
          hop[0][t.node_index] = t.has_next ? {1'b1, t.next_node} : 9'd0;
          acc[0][t.node_index] = t.entry_value;
          loads++;
        end
        blf_pkg::CMD_BUILD: begin
          for (int d = 0; d + 1 < LEVELS; d++)
            for (int i = 0; i < NODES; i++) begin
              if (hop[d][i][8]) begin
                hop[d+1][i] = hop[d][hop[d][i][7:0]];
                acc[d+1][i] = fold_pair(acc[d][i], acc[d][hop[d][i][7:0]]);
              end else begin
                hop[d+1][i] = '0;
                acc[d+1][i] = neutral();
              end
            end
          builds++;
        end
        blf_pkg::CMD_QUERY: begin
          cur = t.node_index;
          r.end_valid = 1'b1;
          r.folded_value = neutral();
          for (int d = LEVELS - 1; d >= 0; d--) begin
            if (t.step_count[d]) begin
              if (!hop[d][cur][8]) begin
                r.end_valid = 1'b0;
                break;
              end
              r.folded_value = fold_pair(r.folded_value, acc[d][cur]);
              cur = hop[d][cur][7:0];
            end
          end
          r.end_node = cur;
          queries++;
          if (r.end_valid) valid_walks++;
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(blf_pkg::out_t got);
      blf_pkg::out_t e;
      if (awaited.size() == 0) begin
        $error("result with no transaction outstanding: %h", got);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.end_node !== e.end_node) begin
        $error("end_node expected %0d actual %0d", e.end_node, got.end_node);
        errors++;
      end
      if (got.end_valid !== e.end_valid) begin
        $error("end_valid expected %0d actual %0d", e.end_valid, got.end_valid);
        errors++;
      end
      if (got.folded_value !== e.folded_value) begin
        $error("folded_value expected %h actual %h", e.folded_value, got.folded_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  blf_pkg::in_t  in_data = '0;
  logic out_valid;
  blf_pkg::out_t out_data;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  lift_scoreboard sb = new();
  int idle_cycles = 0;

  binary_lifting_fold dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_transaction(in_data);
      if (out_valid) sb.check_result(out_data);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_MAX) begin
        $display("binary_lifting_fold_tb: errors");
        $finish;
      end
    end
  end

  function automatic bit [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {64{1'b1}};
      1: return 64'd0;
      2: return {1'b1, 63'd0};
      3: return {1'b0, {63{1'b1}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic bit [59:0] pick_steps();
    bit [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 60'($urandom_range(0, 300));
      4, 5: return w[59:0];
      6: return 60'd1 << $urandom_range(0, 59);
      default: return (60'd1 << $urandom_range(0, 59)) - 60'd1;
    endcase
  endfunction

  function automatic blf_pkg::in_t make_item(logic [1:0] cmd, bit [7:0] node, bit [7:0] nxt,
                                             bit has, bit [63:0] val, bit [59:0] steps);
    blf_pkg::in_t t;
    t.command = cmd;
    t.node_index = node;
    t.next_node = nxt;
    t.has_next = has;
    t.entry_value = val;
    t.step_count = steps;
    return t;
  endfunction

  function automatic blf_pkg::in_t random_item(logic [1:0] cmd);
    return make_item(cmd, 8'($urandom), 8'($urandom), 1'($urandom), pick_value(),
                     pick_steps());
  endfunction

  task automatic send_item(blf_pkg::in_t t);
    int gap, r;
    r = $urandom_range(0, 99);
    gap = (r < 45) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
    @(posedge clk);
  endtask

  initial begin
    bit mode_seq [5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    int nloads;
    blf_pkg::in_t t;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    send_item(make_item(blf_pkg::CMD_QUERY, 8'd0, 8'd0, 1'b0, 64'd0, 60'd0));
    send_item(make_item(blf_pkg::CMD_QUERY, 8'd0, 8'd0, 1'b0, 64'd0, 60'd1));
    send_item(make_item(CMD_NOP, 8'hff, 8'hff, 1'b1, {64{1'b1}}, {60{1'b1}}));
    send_item(make_item(blf_pkg::CMD_LOAD, 8'd255, 8'd0, 1'b1, {1'b0, {63{1'b1}}}, 60'd0));
    send_item(make_item(blf_pkg::CMD_LOAD, 8'd0, 8'd255, 1'b1, {1'b1, 63'd0}, {60{1'b1}}));
    send_item(make_item(blf_pkg::CMD_LOAD, 8'd1, 8'd5, 1'b0, {64{1'b1}}, 60'd0));
    send_item(make_item(blf_pkg::CMD_LOAD, 8'd2, 8'd2, 1'b1, 64'd0, 60'd0));
    send_item(make_item(blf_pkg::CMD_QUERY, 8'd255, 8'd0, 1'b0, 64'd0, 60'd3));
    send_item(make_item(blf_pkg::CMD_BUILD, 8'hff, 8'hff, 1'b1, {64{1'b1}}, {60{1'b1}}));
    send_item(make_item(blf_pkg::CMD_QUERY, 8'd255, 8'd0, 1'b0, 64'd0, {60{1'b1}}));
    send_item(make_item(blf_pkg::CMD_QUERY, 8'd0, 8'd0, 1'b0, 64'd0, 60'd1 << 59));
    send_item(make_item(blf_pkg::CMD_QUERY, 8'd1, 8'd0, 1'b0, 64'd0, 60'd1));
    send_item(make_item(blf_pkg::CMD_QUERY, 8'd2, 8'd0, 1'b0, 64'd0, {60{1'b1}}));
    send_item(make_item(blf_pkg::CMD_QUERY, 8'd255, 8'd0, 1'b0, 64'd0, 60'd0));
    drain();

    foreach (mode_seq[p]) begin
      write_mode(mode_seq[p]);
      while (busy) @(posedge clk);
      nloads = (p == 0) ? NODES : 40;
      for (int i = 0; i < nloads; i++) begin
        t = random_item(blf_pkg::CMD_LOAD);
        if (p == 0) t.node_index = 8'(i);
        if ($urandom_range(0, 15) != 0) t.has_next = 1'b1;
        send_item(t);
        if ($urandom_range(0, 29) == 0) send_item(random_item(blf_pkg::CMD_QUERY));
      end
      send_item(random_item(blf_pkg::CMD_BUILD));
      for (int i = 0; i < 90; i++) begin
        case ($urandom_range(0, 39))
          0: send_item(random_item(CMD_NOP));
          1: send_item(random_item(blf_pkg::CMD_LOAD));
          default: send_item(random_item(blf_pkg::CMD_QUERY));
        endcase
      end
      drain();
    end

    $display("covered %0d loads, %0d builds, %0d queries (%0d walks stayed defined)",
             sb.loads, sb.builds, sb.queries, sb.valid_walks);
    $display("both fold modes, mode rewrites with table refill, stale levels before rebuild");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("binary_lifting_fold_tb: clean");
    end else begin
      $display("binary_lifting_fold_tb: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/blf_pkg.sv
design/blf_ram.sv
design/binary_lifting_fold.sv
tb/sv/binary_lifting_fold_tb.sv
